// ===== rtl/spa_pkg.sv =====
// Shared types, command codes and saturating coordinate helpers for the path absolutizer.
package spa_pkg;

  // Internal coordinate width (Q16.16 at 32); the ports stay 32 bits wide.
  localparam int COORD_BITS = 32;
  localparam int IO_BITS    = 32;
  // Sums and the 2*end - ctl reflection fit in this width before saturation.
  localparam int EXT_BITS   = ((COORD_BITS > IO_BITS) ? COORD_BITS : IO_BITS) + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [IO_BITS-1:0]    io_coord_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;

  localparam ext_t SAT_HI = {{(EXT_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam ext_t SAT_LO = ~SAT_HI;

  typedef enum logic [4:0] {
    KIND_CLOSE        = 5'd0,
    KIND_MOVE_ABS     = 5'd1,
    KIND_MOVE_REL     = 5'd2,
    KIND_LINE_ABS     = 5'd3,
    KIND_LINE_REL     = 5'd4,
    KIND_CUBIC_ABS    = 5'd5,
    KIND_CUBIC_REL    = 5'd6,
    KIND_QUAD_ABS     = 5'd7,
    KIND_QUAD_REL     = 5'd8,
    KIND_ARC_ABS      = 5'd9,
    KIND_ARC_REL      = 5'd10,
    KIND_HORIZ_ABS    = 5'd11,
    KIND_HORIZ_REL    = 5'd12,
    KIND_VERT_ABS     = 5'd13,
    KIND_VERT_REL     = 5'd14,
    KIND_SCUBIC_ABS   = 5'd15,
    KIND_SCUBIC_REL   = 5'd16,
    KIND_SQUAD_ABS    = 5'd17,
    KIND_SQUAD_REL    = 5'd18
  } seg_kind_t;

  localparam logic PRIM_LINE  = 1'b0;
  localparam logic PRIM_CUBIC = 1'b1;

  typedef struct packed {
    logic [4:0] seg_kind;
    logic       path_start;
    io_coord_t  end_x_in;
    io_coord_t  end_y_in;
    io_coord_t  ctl1_x_in;
    io_coord_t  ctl1_y_in;
    io_coord_t  ctl2_x_in;
    io_coord_t  ctl2_y_in;
  } item_t;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t sub_start_x;
    coord_t sub_start_y;
    coord_t refl_x;
    coord_t refl_y;
    logic   start_known;
  } state_t;

  typedef struct packed {
    logic      valid;
    logic      prim_kind;
    logic      close_figure;
    io_coord_t p0_x;
    io_coord_t p0_y;
    io_coord_t p1_x;
    io_coord_t p1_y;
    io_coord_t p2_x;
    io_coord_t p2_y;
    io_coord_t p3_x;
    io_coord_t p3_y;
  } prim_t;

  function automatic ext_t coord_ext(coord_t c);
    return {{(EXT_BITS-COORD_BITS){c[COORD_BITS-1]}}, c};
  endfunction

  function automatic coord_t sat_ext(ext_t v);
    coord_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // Port value plus offset, saturated to the coordinate range.
  function automatic coord_t add_in(io_coord_t v, coord_t ofs);
    ext_t w;
    ext_t o;
    ext_t s;
    w = {{(EXT_BITS-IO_BITS){v[IO_BITS-1]}}, v};
    o = coord_ext(ofs);
    // Narrow coordinates clamp the port value before the add.
    s = coord_ext(sat_ext(w)) + o;
    return sat_ext(s);
  endfunction

  function automatic io_coord_t coord_out(coord_t c);
    ext_t w;
    w = coord_ext(c);
    return w[IO_BITS-1:0];
  endfunction

  // 2*e - c, saturated: the control point mirrored through the end point.
  function automatic coord_t reflect(coord_t e, coord_t c);
    ext_t w;
    w = (coord_ext(e) <<< 1) - coord_ext(c);
    return sat_ext(w);
  endfunction

endpackage

// ===== rtl/spa_step.sv =====
// Per-command datapath: absolutizes one command against the kept points.
module spa_step (
  input  spa_pkg::item_t  item,
  input  spa_pkg::state_t st_q,
  output spa_pkg::state_t st_nxt,
  output spa_pkg::prim_t  prim
);
  import spa_pkg::*;

  state_t    st;
  seg_kind_t kind;
  coord_t    ox, oy;
  coord_t    ex, ey, c1x, c1y, c2x, c2y;
  coord_t    refl_x_new, refl_y_new;

  // A path start clears everything before the command is handled.
  assign st   = item.path_start ? '0 : st_q;
  assign kind = seg_kind_t'(item.seg_kind);
  // Relative codes are the even ones.
  assign ox   = item.seg_kind[0] ? '0 : st.cur_x;
  assign oy   = item.seg_kind[0] ? '0 : st.cur_y;

  assign ex  = add_in(item.end_x_in, ox);
  assign ey  = add_in(item.end_y_in, oy);
  assign c1x = add_in(item.ctl1_x_in, ox);
  assign c1y = add_in(item.ctl1_y_in, oy);
  assign c2x = add_in(item.ctl2_x_in, ox);
  assign c2y = add_in(item.ctl2_y_in, oy);

  assign refl_x_new = reflect(ex, c2x);
  assign refl_y_new = reflect(ey, c2y);

  always_comb begin
    st_nxt = st;
    prim   = '0;
    case (kind)
      KIND_CLOSE: begin
        prim.valid        = 1'b1;
        prim.prim_kind    = PRIM_LINE;
        prim.close_figure = 1'b1;
        prim.p0_x         = coord_out(st.sub_start_x);
        prim.p0_y         = coord_out(st.sub_start_y);
        prim.p3_x         = coord_out(st.cur_x);
        prim.p3_y         = coord_out(st.cur_y);
        st_nxt.start_known = 1'b0;
      end
      KIND_MOVE_ABS, KIND_MOVE_REL: begin
        st_nxt.cur_x = ex;
        st_nxt.cur_y = ey;
        if (!st.start_known) begin
          st_nxt.sub_start_x = ex;
          st_nxt.sub_start_y = ey;
          st_nxt.refl_x      = ex;
          st_nxt.refl_y      = ey;
          st_nxt.start_known = 1'b1;
        end
      end
      KIND_LINE_ABS, KIND_LINE_REL: begin
        prim.valid     = 1'b1;
        prim.prim_kind = PRIM_LINE;
        prim.p0_x      = coord_out(st.cur_x);
        prim.p0_y      = coord_out(st.cur_y);
        prim.p3_x      = coord_out(ex);
        prim.p3_y      = coord_out(ey);
        st_nxt.cur_x   = ex;
        st_nxt.cur_y   = ey;
      end
      KIND_CUBIC_ABS, KIND_CUBIC_REL, KIND_SCUBIC_ABS, KIND_SCUBIC_REL: begin
        prim.valid     = 1'b1;
        prim.prim_kind = PRIM_CUBIC;
        prim.p0_x      = coord_out(st.cur_x);
        prim.p0_y      = coord_out(st.cur_y);
        // Smooth cubics take the mirrored control as their first control.
        if (kind == KIND_SCUBIC_ABS || kind == KIND_SCUBIC_REL) begin
          prim.p1_x = coord_out(st.refl_x);
          prim.p1_y = coord_out(st.refl_y);
        end else begin
          prim.p1_x = coord_out(c1x);
          prim.p1_y = coord_out(c1y);
        end
        prim.p2_x     = coord_out(c2x);
        prim.p2_y     = coord_out(c2y);
        prim.p3_x     = coord_out(ex);
        prim.p3_y     = coord_out(ey);
        st_nxt.refl_x = refl_x_new;
        st_nxt.refl_y = refl_y_new;
        st_nxt.cur_x  = ex;
        st_nxt.cur_y  = ey;
      end
      KIND_HORIZ_ABS, KIND_HORIZ_REL: begin
        prim.valid     = 1'b1;
        prim.prim_kind = PRIM_LINE;
        prim.p0_x      = coord_out(st.cur_x);
        prim.p0_y      = coord_out(st.cur_y);
        prim.p3_x      = coord_out(ex);
        prim.p3_y      = coord_out(st.cur_y);
        st_nxt.cur_x   = ex;
      end
      KIND_VERT_ABS, KIND_VERT_REL: begin
        prim.valid     = 1'b1;
        prim.prim_kind = PRIM_LINE;
        prim.p0_x      = coord_out(st.cur_x);
        prim.p0_y      = coord_out(st.cur_y);
        prim.p3_x      = coord_out(st.cur_x);
        prim.p3_y      = coord_out(ey);
        st_nxt.cur_y   = ey;
      end
      KIND_QUAD_ABS, KIND_QUAD_REL, KIND_ARC_ABS, KIND_ARC_REL,
      KIND_SQUAD_ABS, KIND_SQUAD_REL: begin
        st_nxt.cur_x = ex;
        st_nxt.cur_y = ey;
      end
      default: begin
        // Undefined codes: no beat, only the path start clearing applies.
        st_nxt = st;
      end
    endcase
  end

endmodule

// ===== rtl/svg_path_segment_absolutizer_core.sv =====
// Top level of the path absolutizer: input register, command datapath, result register.
// One path command is taken per cycle and its primitive, if any, passes the input register
// and then the result register before it is presented. The kept points (current point,
// subpath start, mirrored control) are updated in the same cycle the command passes the
// datapath, so consecutive commands stream without gaps; throughput drops only while
// the result register holds a beat the sink has not taken. Moveto, quadratic, arc and
// undefined commands produce no output beat.
module svg_path_segment_absolutizer_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // end_x_in, end_y_in, ctl1_x_in, ctl1_y_in, ctl2_x_in, ctl2_y_in (32 bits each)
  input  logic [191:0] in_tdata,
  // seg_kind [4:0], path_start [5]
  input  logic [5:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (32 bits each)
  output logic [255:0] out_tdata,
  // prim_kind
  output logic         out_tuser,
  // close_figure
  output logic         out_tlast
);
  import spa_pkg::*;

  logic   in_valid_r;
  item_t  item_r;
  state_t state_r;
  state_t state_nxt;
  prim_t  prim_nxt;
  prim_t  prim_r;
  logic   advance;

  assign advance   = !prim_r.valid || out_tready;
  assign in_tready = !in_valid_r || advance;

  spa_step u_step (
    .item   (item_r),
    .st_q   (state_r),
    .st_nxt (state_nxt),
    .prim   (prim_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      prim_r.valid <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        prim_r.valid <= in_valid_r && prim_nxt.valid;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
    // Payload registers, no reset.
    if (in_tvalid && in_tready) begin
      item_r.seg_kind   <= in_tuser[4:0];
      item_r.path_start <= in_tuser[5];
      item_r.end_x_in   <= in_tdata[31:0];
      item_r.end_y_in   <= in_tdata[63:32];
      item_r.ctl1_x_in  <= in_tdata[95:64];
      item_r.ctl1_y_in  <= in_tdata[127:96];
      item_r.ctl2_x_in  <= in_tdata[159:128];
      item_r.ctl2_y_in  <= in_tdata[191:160];
    end
    if (advance && in_valid_r) begin
      prim_r.prim_kind    <= prim_nxt.prim_kind;
      prim_r.close_figure <= prim_nxt.close_figure;
      prim_r.p0_x         <= prim_nxt.p0_x;
      prim_r.p0_y         <= prim_nxt.p0_y;
      prim_r.p1_x         <= prim_nxt.p1_x;
      prim_r.p1_y         <= prim_nxt.p1_y;
      prim_r.p2_x         <= prim_nxt.p2_x;
      prim_r.p2_y         <= prim_nxt.p2_y;
      prim_r.p3_x         <= prim_nxt.p3_x;
      prim_r.p3_y         <= prim_nxt.p3_y;
    end
  end

  assign out_tvalid = prim_r.valid;
  assign out_tuser  = prim_r.prim_kind;
  assign out_tlast  = prim_r.close_figure;
  assign out_tdata  = {prim_r.p3_y, prim_r.p3_x, prim_r.p2_y, prim_r.p2_x,
                       prim_r.p1_y, prim_r.p1_x, prim_r.p0_y, prim_r.p0_x};

endmodule
